// ----- design/afs_pkg.sv -----
// ----------------------------------------------------------------------------
// afs_pkg: shared types and constants for the archive format sniffer
// Holds the prefix and tar-magic layout, the type codes and the word that
// the capture front hands to the classify back end.
// ----------------------------------------------------------------------------
package afs_pkg;

  localparam int PrefixBytes = 64;
  localparam int TextChars   = 8;
  localparam int CountW      = 10;
  localparam logic [CountW-1:0] CountMax = 10'd1023;
  localparam int TarAt       = 257;
  localparam int TarLen      = 8;
  localparam int TxtCntW     = 4;

  localparam logic [4:0] TypeNone   = 5'd0;
  localparam logic [4:0] TypeZip    = 5'd1;
  localparam logic [4:0] Type7z     = 5'd2;
  localparam logic [4:0] TypeRar    = 5'd3;
  localparam logic [4:0] TypeXar    = 5'd4;
  localparam logic [4:0] TypeDmg    = 5'd5;
  localparam logic [4:0] TypePdf    = 5'd6;
  localparam logic [4:0] TypeWim    = 5'd7;
  localparam logic [4:0] TypeCab    = 5'd8;
  localparam logic [4:0] TypeUstar  = 5'd9;
  localparam logic [4:0] TypeGnutar = 5'd10;
  localparam logic [4:0] TypeSqlite = 5'd11;
  localparam logic [4:0] TypeMsi    = 5'd12;
  localparam logic [4:0] TypeDeb    = 5'd13;
  localparam logic [4:0] TypeRpm    = 5'd14;
  localparam logic [4:0] TypeCrx    = 5'd15;
  localparam logic [4:0] TypeXz     = 5'd16;
  localparam logic [4:0] TypeGz     = 5'd17;
  localparam logic [4:0] TypeBz2    = 5'd18;
  localparam logic [4:0] TypeNes    = 5'd19;
  localparam logic [4:0] TypeZ      = 5'd20;
  localparam logic [4:0] TypeLz     = 5'd21;
  localparam logic [4:0] TypeSwf    = 5'd22;
  localparam logic [4:0] TypeEpub   = 5'd23;

  // Snapshot of one finished file, handed from capture to classify.
  typedef struct packed {
    logic [PrefixBytes-1:0][7:0] prefix;
    logic [TarLen-1:0][7:0]      tar;
    logic [TextChars-1:0][7:0]   text;
    logic [CountW-1:0]           count;
    logic                        line_end;
    logic [TxtCntW-1:0]          trimmed;
  } afs_snap_t;

  typedef struct packed {
    logic [4:0]  type_code;
    logic [31:0] version_main;
    logic [7:0]  version_minor;
    logic [31:0] format_flags;
    logic [31:0] image_count;
    logic [15:0] total_parts;
    logic [15:0] part_number;
    logic [63:0] version_text;
    logic [3:0]  version_text_length;
  } afs_result_t;

endpackage

// ----- design/afs_capture.sv -----
// ----------------------------------------------------------------------------
// afs_capture: per-byte capture front
// Stores the prefix, the tar magic and the pdf version text, and hands a
// snapshot word to the queue on the last byte of each file.
// ----------------------------------------------------------------------------
module afs_capture import afs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last,
  output logic       snap_valid,
  input  logic       snap_ready,
  output afs_snap_t  snap
);

  logic [PrefixBytes-1:0][7:0] prefix_r;
  logic [TarLen-1:0][7:0]      tar_r;
  logic [TextChars-1:0][7:0]   text_r;
  logic [CountW-1:0]           count_r;
  logic                        line_end_r;
  logic                        started_r;
  logic [TxtCntW-1:0]          stored_r;
  logic [TxtCntW-1:0]          trimmed_r;

  logic acc, is_eol, is_sp, txt_on, room;

  assign in_ready   = snap_ready;
  assign acc        = in_valid && in_ready;
  assign snap_valid = in_valid && in_last;
  assign is_eol     = (in_data_byte == 8'h0D) || (in_data_byte == 8'h0A);
  assign is_sp      = (in_data_byte == 8'h20) || (in_data_byte == 8'h09) ||
                      (in_data_byte == 8'h0B) || (in_data_byte == 8'h0C);
  assign txt_on     = (count_r >= CountW'(5)) && !line_end_r;
  assign room       = stored_r < TxtCntW'(TextChars);

  // Store payload bytes at their offsets.
  always_ff @(posedge clk) begin
    if (acc) begin
      for (int i = 0; i < PrefixBytes; i++)
        if (count_r == CountW'(i)) prefix_r[i] <= in_data_byte;
      for (int i = 0; i < TarLen; i++)
        if (count_r == CountW'(TarAt + i)) tar_r[i] <= in_data_byte;
      if (txt_on && !is_eol && room && (started_r || !is_sp))
        text_r[stored_r[$clog2(TextChars)-1:0]] <= in_data_byte;
    end
  end

  // Advance per-file counters; clear them after the last byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      line_end_r <= 1'b0;
      started_r  <= 1'b0;
      stored_r   <= '0;
      trimmed_r  <= '0;
    end else if (acc) begin
      if (in_last) begin
        count_r    <= '0;
        line_end_r <= 1'b0;
        started_r  <= 1'b0;
        stored_r   <= '0;
        trimmed_r  <= '0;
      end else begin
        if (count_r != CountMax) count_r <= count_r + 1'b1;
        if (txt_on) begin
          if (is_eol) line_end_r <= 1'b1;
          else if (is_sp) begin
            if (started_r && room) stored_r <= stored_r + 1'b1;
          end else begin
            started_r <= 1'b1;
            if (room) begin
              stored_r  <= stored_r + 1'b1;
              trimmed_r <= stored_r + 1'b1;
            end else trimmed_r <= TxtCntW'(TextChars);
          end
        end
      end
    end
  end

  // Build the snapshot with the last byte folded in.
  always_comb begin
    snap          = '0;
    snap.prefix   = prefix_r;
    snap.tar      = tar_r;
    snap.text     = text_r;
    snap.line_end = line_end_r;
    snap.trimmed  = trimmed_r;
    snap.count    = (count_r != CountMax) ? count_r + 1'b1 : count_r;
    for (int i = 0; i < PrefixBytes; i++)
      if (count_r == CountW'(i)) snap.prefix[i] = in_data_byte;
    for (int i = 0; i < TarLen; i++)
      if (count_r == CountW'(TarAt + i)) snap.tar[i] = in_data_byte;
    if (txt_on) begin
      if (is_eol) snap.line_end = 1'b1;
      else if (!is_sp || started_r) begin
        if (room) snap.text[stored_r[$clog2(TextChars)-1:0]] = in_data_byte;
        if (!is_sp) snap.trimmed = room ? stored_r + 1'b1 : TxtCntW'(TextChars);
      end
    end
  end

endmodule

// ----- design/afs_queue.sv -----
// ----------------------------------------------------------------------------
// afs_queue: two-entry snapshot queue
// Decouples capture from classify so each side stalls on its own.
// ----------------------------------------------------------------------------
module afs_queue import afs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  afs_snap_t wr_data,
  output logic      rd_valid,
  input  logic      rd_ready,
  output afs_snap_t rd_data
);

  afs_snap_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;
  assign rd_data  = mem_r[rp_r];

  // Hold entries.
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  // Advance pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !rd) |=> cnt_r == 2'd2)
    else $error("full queue lost an entry");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wp_r == rp_r)
    else $error("queue pointers disagree with count");

endmodule

// ----- design/afs_classify.sv -----
// ----------------------------------------------------------------------------
// afs_classify: signature check back end
// Tests signatures of one snapshot in priority order and registers the result.
// ----------------------------------------------------------------------------
module afs_classify import afs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        snap_valid,
  output logic        snap_ready,
  input  afs_snap_t   snap,
  output logic        res_valid,
  input  logic        res_ready,
  output afs_result_t res
);

  afs_result_t res_r, res_nxt;
  logic        valid_r;

  localparam logic [27:0][7:0] Epub = "piz+bupe/noitacilppaepytemim";

  function automatic logic [7:0] pb(input afs_snap_t s, input int i);
    pb = s.prefix[i];
  endfunction

  function automatic logic [31:0] le32(input afs_snap_t s, input int i);
    le32 = {s.prefix[i+3], s.prefix[i+2], s.prefix[i+1], s.prefix[i]};
  endfunction

  function automatic logic [31:0] be32(input afs_snap_t s, input int i);
    be32 = {s.prefix[i], s.prefix[i+1], s.prefix[i+2], s.prefix[i+3]};
  endfunction

  assign snap_ready = !valid_r || res_ready;
  assign res_valid  = valid_r;
  assign res        = res_r;

  always_comb begin
    logic [CountW-1:0] n;
    logic [7:0] b2, b3;
    logic epub_ok;
    n = snap.count;
    b2 = pb(snap, 2);
    b3 = pb(snap, 3);
    epub_ok = 1'b1;
    for (int i = 0; i < 28; i++)
      if (pb(snap, 30 + i) != Epub[i]) epub_ok = 1'b0;
    res_nxt = '0;
    if (n >= 4 && pb(snap, 0) == 8'h50 && pb(snap, 1) == 8'h4B &&
        (b2 == 8'd3 || b2 == 8'd5 || b2 == 8'd7) &&
        (b3 == 8'd4 || b3 == 8'd6 || b3 == 8'd8)) begin
      res_nxt.type_code = TypeZip;
    end else if (n >= 8 && {pb(snap,0),pb(snap,1),pb(snap,2),pb(snap,3),pb(snap,4),
                 pb(snap,5)} == {"7z", 32'hBCAF271C}) begin
      res_nxt.type_code     = Type7z;
      res_nxt.version_main  = {24'd0, pb(snap, 6)};
      res_nxt.version_minor = pb(snap, 7);
    end else if (n >= 8 && be32(snap, 0) == 32'h52617221 &&
                 be32(snap, 4) == 32'h1A070100) begin
      res_nxt.type_code = TypeRar; res_nxt.version_main = 32'd5;
    end else if (n >= 7 && be32(snap, 0) == 32'h52617221 &&
                 {pb(snap,4),pb(snap,5),pb(snap,6)} == 24'h1A0700) begin
      res_nxt.type_code = TypeRar; res_nxt.version_main = 32'd4;
    end else if (n >= 28 && be32(snap, 0) == "xar!" &&
                 {pb(snap,4),pb(snap,5)} >= 16'd28) begin
      res_nxt.type_code    = TypeXar;
      res_nxt.version_main = {16'd0, pb(snap, 6), pb(snap, 7)};
    end else if (n >= 512 && be32(snap, 0) == "koly" && be32(snap, 8) == 32'd512) begin
      res_nxt.type_code = TypeDmg; res_nxt.version_main = be32(snap, 4);
    end else if (n >= 8 && be32(snap, 0) == "%PDF" && pb(snap, 4) == "-" &&
                 snap.line_end) begin
      res_nxt.type_code = TypePdf;
      for (int i = 0; i < TextChars; i++)
        if (TxtCntW'(i) < snap.trimmed) res_nxt.version_text[8*i +: 8] = snap.text[i];
      res_nxt.version_text_length = snap.trimmed;
    end else if (n >= 208 && be32(snap, 0) == "MSWI" && be32(snap, 4) == {"M", 24'd0} &&
                 le32(snap, 8) >= 32'd208) begin
      res_nxt.type_code    = TypeWim;
      res_nxt.version_main = le32(snap, 12);
      res_nxt.format_flags = le32(snap, 16);
      res_nxt.image_count  = le32(snap, 44);
      res_nxt.total_parts  = {pb(snap, 43), pb(snap, 42)};
      res_nxt.part_number  = {pb(snap, 41), pb(snap, 40)};
    end else if (n >= 40 && be32(snap, 0) == "MSCF" && be32(snap, 4) == 32'd0) begin
      res_nxt.type_code     = TypeCab;
      res_nxt.version_main  = {24'd0, pb(snap, 25)};
      res_nxt.version_minor = pb(snap, 24);
    end else if (n >= 500 && {snap.tar[0],snap.tar[1],snap.tar[2],snap.tar[3],
                 snap.tar[4],snap.tar[5]} == {"ustar", 8'd0}) begin
      res_nxt.type_code = TypeUstar;
    end else if (n >= 500 && {snap.tar[0],snap.tar[1],snap.tar[2],snap.tar[3],
                 snap.tar[4],snap.tar[5],snap.tar[6],snap.tar[7]} ==
                 {"ustar  ", 8'd0}) begin
      res_nxt.type_code = TypeGnutar;
    end else if (n >= 20 && {be32(snap,0),be32(snap,4),be32(snap,8),pb(snap,12)} ==
                 "SQLite format" && pb(snap, 15) == 8'd0) begin
      res_nxt.type_code    = TypeSqlite;
      res_nxt.version_main = {24'd0, pb(snap, 14)};
    end else if (n >= 8 && {be32(snap,0),be32(snap,4)} == 64'hD0CF11E0A1B11AE1) begin
      res_nxt.type_code = TypeMsi;
    end else if (n >= 21 && {be32(snap,0),be32(snap,4),be32(snap,8),be32(snap,12),
                 be32(snap,16),pb(snap,20)} == "!<arch>\ndebian-binary") begin
      res_nxt.type_code = TypeDeb;
    end else if (n > 96 && be32(snap, 0) == 32'hEDABEEDB) begin
      res_nxt.type_code = TypeRpm;
    end else if (n >= 4 && be32(snap, 0) == "Cr24") begin
      res_nxt.type_code = TypeCrx;
    end else if (n >= 6 && {be32(snap,0),pb(snap,4),pb(snap,5)} == 48'hFD377A585A00) begin
      res_nxt.type_code = TypeXz;
    end else if (n >= 3 && {pb(snap,0),pb(snap,1),b2} == 24'h1F8B08) begin
      res_nxt.type_code = TypeGz;
    end else if (n >= 3 && {pb(snap,0),pb(snap,1),b2} == 24'h425A68) begin
      res_nxt.type_code = TypeBz2;
    end else if (n >= 4 && be32(snap, 0) == 32'h4E45531A) begin
      res_nxt.type_code = TypeNes;
    end else if (n >= 4 && be32(snap, 0) == 32'h1FA01F9D) begin
      res_nxt.type_code = TypeZ;
    end else if (n >= 4 && be32(snap, 0) == 32'h4C5A4950) begin
      res_nxt.type_code = TypeLz;
    end else if (n > 2 && (pb(snap,0) == 8'h43 || pb(snap,0) == 8'h46) &&
                 pb(snap,1) == 8'h57 && b2 == 8'h53) begin
      res_nxt.type_code = TypeSwf;
    end else if (n > 57 && be32(snap, 0) == 32'h504B0304 && epub_ok) begin
      res_nxt.type_code = TypeEpub;
    end
  end

  // Hold the result until taken.
  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (snap_ready) valid_r <= snap_valid;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !res_ready) |=> valid_r && $stable(res_r))
    else $error("stalled result changed");
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> res_r.version_text_length <= TxtCntW'(TextChars))
    else $error("text length too large");
  a_txt: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && res_r.type_code != TypePdf) |-> res_r.version_text_length == '0)
    else $error("text length on non-pdf type");

endmodule

// ----- design/archive_format_sniffer.sv -----
// ----------------------------------------------------------------------------
// archive_format_sniffer: streaming archive signature detector
//
//   channel  direction  payload
//   in_      input      data_byte, last
//   out_     output     type fields, one word per file
//
// One byte per cycle while the queue has room. After its last byte is accepted,
// a file's result is registered in the queue, then in the classify register.
// A two-entry queue between capture and classify lets bytes keep flowing
// while a result waits; once the queue is full, input stalls.
// Reset is synchronous, active low, and clears the per-file counters.
// ----------------------------------------------------------------------------
module archive_format_sniffer import afs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_type_code,
  output logic [31:0] out_version_main,
  output logic [7:0]  out_version_minor,
  output logic [31:0] out_format_flags,
  output logic [31:0] out_image_count,
  output logic [15:0] out_total_parts,
  output logic [15:0] out_part_number,
  output logic [63:0] out_version_text,
  output logic [3:0]  out_version_text_length
);

  afs_snap_t   s_data, q_data;
  logic        s_valid, s_ready, q_valid, q_ready;
  afs_result_t r;

  afs_capture u_cap (.clk, .rst_n, .in_valid, .in_ready, .in_data_byte, .in_last,
    .snap_valid(s_valid), .snap_ready(s_ready), .snap(s_data));

  afs_queue u_q (.clk, .rst_n, .wr_valid(s_valid), .wr_ready(s_ready), .wr_data(s_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data));

  afs_classify u_cls (.clk, .rst_n, .snap_valid(q_valid), .snap_ready(q_ready),
    .snap(q_data), .res_valid(out_valid), .res_ready(out_ready), .res(r));

  assign out_type_code           = r.type_code;
  assign out_version_main        = r.version_main;
  assign out_version_minor       = r.version_minor;
  assign out_format_flags        = r.format_flags;
  assign out_image_count         = r.image_count;
  assign out_total_parts         = r.total_parts;
  assign out_part_number         = r.part_number;
  assign out_version_text        = r.version_text;
  assign out_version_text_length = r.version_text_length;

endmodule

// ----- tb/archive_format_sniffer_tb.sv -----
// ----------------------------------------------------------------------------
// archive_format_sniffer_tb: self-checking bench for the format sniffer
// Streams whole files byte by byte, predicts the classification of each
// file as its bytes are accepted, and compares every result word field by
// field against the oldest prediction. Both sides idle at random, apart from the last random run.
// ----------------------------------------------------------------------------
module archive_format_sniffer_tb import afs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [4:0]  out_type_code;
  logic [31:0] out_version_main;
  logic [7:0]  out_version_minor;
  logic [31:0] out_format_flags;
  logic [31:0] out_image_count;
  logic [15:0] out_total_parts;
  logic [15:0] out_part_number;
  logic [63:0] out_version_text;
  logic [3:0]  out_version_text_length;

  archive_format_sniffer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_data_byte(in_data_byte), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_type_code(out_type_code), .out_version_main(out_version_main),
    .out_version_minor(out_version_minor), .out_format_flags(out_format_flags),
    .out_image_count(out_image_count), .out_total_parts(out_total_parts),
    .out_part_number(out_part_number), .out_version_text(out_version_text),
    .out_version_text_length(out_version_text_length)
  );

  // predictor state for the file in flight
  logic [7:0]  head_bytes [PrefixBytes];
  logic [7:0]  tar_bytes [TarLen];
  logic [7:0]  pdf_chars [TextChars];
  int unsigned seen_count;
  bit          eol_seen;
  bit          pdf_started;
  int unsigned pdf_stored;
  int unsigned pdf_trimmed;

  afs_result_t expected_types [$];
  int          errors;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] hb(int i);
    return (i < PrefixBytes) ? head_bytes[i] : 8'h00;
  endfunction

  function automatic logic [31:0] le32_at(int i);
    return {hb(i+3), hb(i+2), hb(i+1), hb(i)};
  endfunction

  function automatic bit head_is(int at, byte unsigned sig []);
    foreach (sig[k]) if (hb(at + k) != sig[k]) return 0;
    return 1;
  endfunction

  function automatic bit tar_is(byte unsigned sig []);
    foreach (sig[k]) if (tar_bytes[k] != sig[k]) return 0;
    return 1;
  endfunction

  function automatic bit blank(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
  endfunction

  // Classify the finished file in the predictor.
  function automatic afs_result_t classify_file();
    afs_result_t r;
    int unsigned n;
    logic [7:0] b2, b3;
    r = '0;
    n = seen_count;
    b2 = hb(2);
    b3 = hb(3);
    if (n >= 4 && hb(0) == 8'h50 && hb(1) == 8'h4B && (b2 == 3 || b2 == 5 || b2 == 7)
        && (b3 == 4 || b3 == 6 || b3 == 8)) begin
      r.type_code = TypeZip;
    end else if (n >= 8 && head_is(0, '{"7", "z", 8'hBC, 8'hAF, 8'h27, 8'h1C})) begin
      r.type_code = Type7z;
      r.version_main = 32'(hb(6));
      r.version_minor = hb(7);
    end else if (n >= 8 && head_is(0, '{8'h52, 8'h61, 8'h72, 8'h21, 8'h1A, 8'h07, 8'h01, 8'h00}))
        begin
      r.type_code = TypeRar;
      r.version_main = 32'd5;
    end else if (n >= 7 && head_is(0, '{8'h52, 8'h61, 8'h72, 8'h21, 8'h1A, 8'h07, 8'h00})) begin
      r.type_code = TypeRar;
      r.version_main = 32'd4;
    end else if (n >= 28 && head_is(0, '{"x", "a", "r", "!"}) && {hb(4), hb(5)} >= 28) begin
      r.type_code = TypeXar;
      r.version_main = 32'({hb(6), hb(7)});
    end else if (n >= 512 && head_is(0, '{"k", "o", "l", "y"})
        && {hb(8), hb(9), hb(10), hb(11)} == 512) begin
      r.type_code = TypeDmg;
      r.version_main = {hb(4), hb(5), hb(6), hb(7)};
    end else if (n >= 8 && eol_seen && head_is(0, '{"%", "P", "D", "F", "-"})) begin
      r.type_code = TypePdf;
      for (int i = 0; i < pdf_trimmed && i < TextChars; i++)
        r.version_text[8*i +: 8] = pdf_chars[i];
      r.version_text_length = 4'(pdf_trimmed);
    end else if (n >= 208 && head_is(0, '{"M", "S", "W", "I", "M", 0, 0, 0})
        && le32_at(8) >= 208) begin
      r.type_code = TypeWim;
      r.version_main = le32_at(12);
      r.format_flags = le32_at(16);
      r.image_count = le32_at(44);
      r.total_parts = {hb(43), hb(42)};
      r.part_number = {hb(41), hb(40)};
    end else if (n >= 40 && head_is(0, '{"M", "S", "C", "F", 0, 0, 0, 0})) begin
      r.type_code = TypeCab;
      r.version_main = 32'(hb(25));
      r.version_minor = hb(24);
    end else if (n >= 500 && tar_is('{"u", "s", "t", "a", "r", 0})) begin
      r.type_code = TypeUstar;
    end else if (n >= 500 && tar_is('{"u", "s", "t", "a", "r", " ", " ", 0})) begin
      r.type_code = TypeGnutar;
    end else if (n >= 20 && hb(15) == 0
        && head_is(0, '{"S", "Q", "L", "i", "t", "e", " ", "f", "o", "r", "m", "a", "t"})) begin
      r.type_code = TypeSqlite;
      r.version_main = 32'(hb(14));
    end else if (n >= 8 && head_is(0, '{8'hD0, 8'hCF, 8'h11, 8'hE0, 8'hA1, 8'hB1, 8'h1A, 8'hE1}))
      r.type_code = TypeMsi;
    else if (n >= 21 && head_is(0, '{"!", "<", "a", "r", "c", "h", ">", 8'h0A, "d", "e", "b",
        "i", "a", "n", "-", "b", "i", "n", "a", "r", "y"}))
      r.type_code = TypeDeb;
    else if (n > 96 && head_is(0, '{8'hED, 8'hAB, 8'hEE, 8'hDB})) r.type_code = TypeRpm;
    else if (n >= 4 && head_is(0, '{"C", "r", "2", "4"})) r.type_code = TypeCrx;
    else if (n >= 6 && head_is(0, '{8'hFD, 8'h37, 8'h7A, 8'h58, 8'h5A, 8'h00}))
      r.type_code = TypeXz;
    else if (n >= 3 && head_is(0, '{8'h1F, 8'h8B, 8'h08})) r.type_code = TypeGz;
    else if (n >= 3 && head_is(0, '{8'h42, 8'h5A, 8'h68})) r.type_code = TypeBz2;
    else if (n >= 4 && head_is(0, '{8'h4E, 8'h45, 8'h53, 8'h1A})) r.type_code = TypeNes;
    else if (n >= 4 && head_is(0, '{8'h1F, 8'hA0, 8'h1F, 8'h9D})) r.type_code = TypeZ;
    else if (n >= 4 && head_is(0, '{8'h4C, 8'h5A, 8'h49, 8'h50})) r.type_code = TypeLz;
    else if (n > 2 && (hb(0) == 8'h43 || hb(0) == 8'h46) && hb(1) == 8'h57 && hb(2) == 8'h53)
      r.type_code = TypeSwf;
    else if (n > 57 && hb(0) == 8'h50 && hb(1) == 8'h4B && b2 == 3 && b3 == 4
        && head_is(30, '{"m", "i", "m", "e", "t", "y", "p", "e", "a", "p", "p", "l", "i", "c",
        "a", "t", "i", "o", "n", "/", "e", "p", "u", "b", "+", "z", "i", "p"}))
      r.type_code = TypeEpub;
    return r;
  endfunction

  // Fold one accepted byte into the predictor; queue a result on last.
  task automatic absorb_byte(logic [7:0] b, logic lst);
    if (seen_count < PrefixBytes) head_bytes[seen_count] = b;
    if (seen_count >= TarAt && seen_count < TarAt + TarLen) tar_bytes[seen_count - TarAt] = b;
    if (seen_count >= 5 && !eol_seen) begin
      if (b == 8'h0D || b == 8'h0A) begin
        eol_seen = 1;
      end else if (blank(b)) begin
        if (pdf_started && pdf_stored < TextChars) pdf_chars[pdf_stored++] = b;
      end else begin
        pdf_started = 1;
        if (pdf_stored < TextChars) begin
          pdf_chars[pdf_stored++] = b;
          pdf_trimmed = pdf_stored;
        end else begin
          pdf_trimmed = TextChars;
        end
      end
    end
    if (seen_count < 1023) seen_count++;
    if (lst) begin
      expected_types.push_back(classify_file());
      seen_count = 0;
      eol_seen = 0;
      pdf_started = 0;
      pdf_stored = 0;
      pdf_trimmed = 0;
    end
  endtask

  // Send one byte: drop valid for a random idle, then hold it until accepted.
  task automatic send_byte(logic [7:0] b, logic lst);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last <= lst;
    do @(posedge clk); while (!in_ready);
    absorb_byte(b, lst);
  endtask

  // Send a file built from a header, padded with random bytes to len.
  task automatic send_file(byte unsigned hdr [], int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = (i < hdr.size()) ? hdr[i] : 8'($urandom_range(255));
      send_byte(b, i == len - 1);
    end
  endtask

  // Drop valid and wait until every predicted word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_types.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Receiver: random stall, then check each result word.
  always @(posedge clk) begin
    afs_result_t exp_r, got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_type_code, out_version_main, out_version_minor, out_format_flags,
               out_image_count, out_total_parts, out_part_number, out_version_text,
               out_version_text_length};
        if (expected_types.size() == 0) begin
          $display("%0t: unexpected result word type %0d", $time, out_type_code);
          errors++;
        end else begin
          exp_r = expected_types.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch type exp %0d act %0d", $time, exp_r.type_code, got.type_code);
            $display("  vmain exp %h act %h vminor exp %h act %h", exp_r.version_main,
                     got.version_main, exp_r.version_minor, got.version_minor);
            $display("  flags exp %h act %h images exp %h act %h", exp_r.format_flags,
                     got.format_flags, exp_r.image_count, got.image_count);
            $display("  parts exp %h/%h act %h/%h", exp_r.total_parts, exp_r.part_number,
                     got.total_parts, got.part_number);
            $display("  text exp %h/%0d act %h/%0d", exp_r.version_text,
                     exp_r.version_text_length, got.version_text, got.version_text_length);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles with no accepted byte and no accepted result word.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Directed: each format but the tar ones and epub (zip wins there), extremes and the pdf trimming cases.
  task automatic test_directed();
    send_file('{8'h50, 8'h4B, 3, 4}, 4);
    send_file('{"P", "K", 3, 4, 0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,
                "m", "i", "m", "e", "t", "y", "p", "e", "a", "p", "p", "l", "i", "c",
                "a", "t", "i", "o", "n", "/", "e", "p", "u", "b", "+", "z", "i", "p"}, 70);
    send_file('{"7", "z", 8'hBC, 8'hAF, 8'h27, 8'h1C, 0, 4}, 8);
    send_file('{8'h52, 8'h61, 8'h72, 8'h21, 8'h1A, 8'h07, 8'h01, 8'h00}, 8);
    send_file('{8'h52, 8'h61, 8'h72, 8'h21, 8'h1A, 8'h07, 8'h00}, 7);
    send_file('{"x", "a", "r", "!", 0, 28, 0, 1}, 28);
    // long enough to saturate the byte count
    send_file('{"k", "o", "l", "y", 0, 0, 0, 4, 0, 0, 2, 0}, 1030);
    send_file('{"%", "P", "D", "F", "-", " ", "1", ".", "7", " ", 8'h0D}, 20);
    send_file('{"%", "P", "D", "F", "-", "1", "2", "3", "4", "5", "6", "7", "8", "9",
                8'h0A}, 16);
    send_file('{"%", "P", "D", "F", "-", "1", ".", "4"}, 8);
    send_file('{"M", "S", "W", "I", "M", 0, 0, 0, 8'hD0, 0, 0, 0}, 208);
    send_file('{"M", "S", "C", "F", 0, 0, 0, 0}, 40);
    send_file('{"S", "Q", "L", "i", "t", "e", " ", "f", "o", "r", "m", "a", "t", 0, 3, 0},
              20);
    send_file('{8'hD0, 8'hCF, 8'h11, 8'hE0, 8'hA1, 8'hB1, 8'h1A, 8'hE1}, 8);
    send_file('{"!", "<", "a", "r", "c", "h", ">", 8'h0A, "d", "e", "b",
                "i", "a", "n", "-", "b", "i", "n", "a", "r", "y"}, 21);
    send_file('{8'hED, 8'hAB, 8'hEE, 8'hDB}, 97);
    send_file('{"C", "r", "2", "4"}, 4);
    send_file('{8'hFD, 8'h37, 8'h7A, 8'h58, 8'h5A, 8'h00}, 6);
    send_file('{8'h1F, 8'h8B, 8'h08}, 3);
    send_file('{8'h42, 8'h5A, 8'h68}, 3);
    send_file('{8'h4E, 8'h45, 8'h53, 8'h1A}, 4);
    send_file('{8'h1F, 8'hA0, 8'h1F, 8'h9D}, 4);
    send_file('{8'h4C, 8'h5A, 8'h49, 8'h50}, 4);
    send_file('{"F", "W", "S"}, 3);
    send_file('{8'hFF}, 1);
  endtask

  // Tar: random filler with the magic placed at offset 257.
  task automatic send_tar(bit gnu);
    logic [7:0] b;
    byte unsigned mg [8];
    int len;
    if (gnu) mg = '{"u", "s", "t", "a", "r", " ", " ", 0};
    else mg = '{"u", "s", "t", "a", "r", 0, 0, 0};
    len = $urandom_range(499, 520);
    for (int i = 0; i < len; i++) begin
      b = (i >= TarAt && i < TarAt + TarLen) ? mg[i - TarAt] : 8'($urandom_range(255));
      if (i < 4) b = 8'h00;
      send_byte(b, i == len - 1);
    end
  endtask

  // Random: mostly well-formed headers with random tails and near misses.
  task automatic test_random(int n_bytes);
    int sent;
    byte unsigned hdr [];
    int len;
    sent = 0;
    while (sent < n_bytes) begin
      case ($urandom_range(11))
        0: hdr = '{"7", "z", 8'hBC, 8'hAF, 8'h27, 8'h1C};
        1: hdr = '{8'h52, 8'h61, 8'h72, 8'h21, 8'h1A, 8'h07, $urandom_range(1), 8'h00};
        2: hdr = '{"x", "a", "r", "!", 0, $urandom_range(20, 40)};
        3: hdr = '{"%", "P", "D", "F", "-", $urandom_range(8, 13), $urandom_range(32, 57),
                   $urandom_range(9, 13), "1", $urandom_range(32, 57), 8'h0A};
        4: hdr = '{"M", "S", "W", "I", "M", 0, 0, 0, $urandom_range(200, 215), 0, 0, 0};
        5: hdr = '{"M", "S", "C", "F", 0, 0, 0, 0};
        6: hdr = '{"S", "Q", "L", "i", "t", "e", " ", "f", "o", "r", "m", "a", "t", 0,
                   $urandom_range(255), $urandom_range(1)};
        7: hdr = '{8'h50, 8'h4B, $urandom_range(2, 8), $urandom_range(2, 8)};
        8: hdr = '{$urandom_range(8'h1E, 8'h20), $urandom_range(8'h8A, 8'hA1), 8'h1F};
        9: hdr = '{$urandom_range(8'h42, 8'h47), $urandom_range(8'h56, 8'h5A),
                   $urandom_range(8'h52, 8'h68)};
        default: hdr = '{$urandom_range(255), $urandom_range(255)};
      endcase
      if ($urandom_range(29) == 0) begin
        send_tar(1'($urandom_range(1)));
        sent += 510;
        continue;
      end
      len = $urandom_range(1) ? $urandom_range(1, 30) : $urandom_range(30, 230);
      if ($urandom_range(99) == 0) len = $urandom_range(1020, 1100);
      send_file(hdr, len);
      sent += len;
    end
  endtask

  initial begin
    errors = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_last = 1'b0;
    out_ready = 1'b0;
    seen_count = 0;
    eol_seen = 0;
    pdf_started = 0;
    pdf_stored = 0;
    pdf_trimmed = 0;
    send_idle_pct = 33;
    recv_idle_pct = 57;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    // sender holds off until every predicted type has come back
    drain_results();
    test_random(120);
    send_idle_pct = 57;
    recv_idle_pct = 33;
    test_random(120);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(120);
    drain_results();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
